// ===== sv/sac_lru_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_lru_pkg
// Geometry, cost constants and request/response/row types shared by the
// set-associative cache LRU tag directory.
// ----------------------------------------------------------------------------
package sac_lru_pkg;

  localparam int unsigned SETS        = 256;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned BLOCK_BYTES = 16;

  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_BITS    = $clog2(SETS);
  localparam int unsigned TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int unsigned WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_BITS    = WAY_BITS;

  localparam int unsigned COST_BITS   = 16;
  localparam int unsigned CNT_BITS    = 32;
  localparam int unsigned TOTAL_BITS  = 64;
  localparam logic [COST_BITS-1:0] MEM_COST = COST_BITS'(100 * (BLOCK_BYTES / 4));
  localparam logic [COST_BITS-1:0] HIT_COST = COST_BITS'(1);

  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOC_ON_WRITE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_BACK_MODE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic                  victim_written;
    logic [COST_BITS-1:0]  access_cycles;
    logic [CNT_BITS-1:0]   load_hit_count;
    logic [CNT_BITS-1:0]   load_miss_count;
    logic [CNT_BITS-1:0]   store_hit_count;
    logic [CNT_BITS-1:0]   store_miss_count;
    logic [TOTAL_BITS-1:0] cycle_total;
  } rsp_t;

  typedef struct packed {
    logic [WAYS-1:0]               valid;
    logic [WAYS-1:0]               dirty;
    logic [WAYS-1:0][AGE_BITS-1:0] age;
    logic [WAYS-1:0][TAG_BITS-1:0] tag;
  } row_t;

endpackage

// ===== sv/set_assoc_cache_lru_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tracker_unit
// Tag directory of a 4-way write-back cache with true LRU replacement,
// hit/miss counters and a running cycle total.
//
//   channel   ports                               direction
//   request   start, busy, req_i                  in (busy out)
//   response  rsp_valid_o, rsp_o                  out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     in
//
// every request gets a set row read, then compare, LRU update and write back
// in the lookup cycle (none on a store miss without allocate); busy is high
// during lookup so the next read always sees the written row. the response
// strobe follows in the cycle after lookup and cannot be stalled. reset
// empties all sets at once through per-row flags, no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  sac_lru_pkg::req_t                  req_i,
  output logic                               rsp_valid_o,
  output sac_lru_pkg::rsp_t                  rsp_o,
  input  logic                               cfg_we_i,
  input  logic [sac_lru_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sac_lru_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import sac_lru_pkg::*;

  typedef enum logic {ST_IDLE, ST_LOOK} state_e;

  state_e                state_q;
  req_t                  req_q;
  logic                  alloc_q;
  logic                  wbm_q;
  logic                  rsp_valid_q;
  logic                  hit_q;
  logic                  wrote_q;
  logic [COST_BITS-1:0]  cost_q;
  logic [CNT_BITS-1:0]   ld_hit_q;
  logic [CNT_BITS-1:0]   ld_miss_q;
  logic [CNT_BITS-1:0]   st_hit_q;
  logic [CNT_BITS-1:0]   st_miss_q;
  logic [TOTAL_BITS-1:0] total_q;

  logic                  accept;
  row_t                  row;
  row_t                  row_d;
  logic                  wr_en;
  logic [TAG_BITS-1:0]   tag;
  logic                  store;
  logic                  hit;
  logic [WAY_BITS-1:0]   hit_way;
  logic                  inv_found;
  logic [WAY_BITS-1:0]   inv_way;
  logic [WAY_BITS-1:0]   lru_way;
  logic [AGE_BITS-1:0]   oldest;
  logic [WAY_BITS-1:0]   sel_way;
  logic [AGE_BITS:0]     prior;
  logic                  do_alloc;
  logic                  wrote;
  logic [COST_BITS-1:0]  cost;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_LOOK);

  sac_lru_dir_mem u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (req_i.address[OFFSET_BITS +: SET_BITS]),
    .rd_row_o (row),
    .wr_en_i  (wr_en),
    .wr_set_i (req_q.address[OFFSET_BITS +: SET_BITS]),
    .wr_row_i (row_d)
  );

  assign tag   = req_q.address[ADDR_BITS-1 -: TAG_BITS];
  assign store = req_q.operation;

  // way lookup and victim choice
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    oldest    = row.age[0];
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row.valid[w] && (row.tag[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!inv_found && !row.valid[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_BITS'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (row.age[w] > oldest) begin
        oldest  = row.age[w];
        lru_way = WAY_BITS'(w);
      end
    end
  end

  // row update
  always_comb begin
    priority if (hit) begin
      sel_way = hit_way;
      prior   = {1'b0, row.age[hit_way]};
    end else if (inv_found) begin
      sel_way = inv_way;
      prior   = (AGE_BITS+1)'(WAYS);
    end else begin
      sel_way = lru_way;
      prior   = {1'b0, oldest};
    end
    do_alloc = hit || !store || alloc_q;
    wrote    = !hit && do_alloc && !inv_found && row.dirty[lru_way] && wbm_q;
    priority if (hit) begin
      cost = HIT_COST;
    end else if (wrote) begin
      cost = MEM_COST + MEM_COST;
    end else begin
      cost = MEM_COST;
    end
    row_d = row;
    for (int v = 0; v < WAYS; v++) begin
      if ((WAY_BITS'(v) != sel_way) && row.valid[v] && ({1'b0, row.age[v]} < prior)) begin
        row_d.age[v] = row.age[v] + AGE_BITS'(1);
      end
    end
    row_d.age[sel_way]   = '0;
    row_d.valid[sel_way] = 1'b1;
    if (hit) begin
      row_d.dirty[sel_way] = row.dirty[sel_way] | store;
    end else begin
      row_d.dirty[sel_way] = store;
      row_d.tag[sel_way]   = tag;
    end
    wr_en = (state_q == ST_LOOK) && do_alloc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      alloc_q     <= 1'b1;
      wbm_q       <= 1'b1;
      rsp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      wrote_q     <= 1'b0;
      cost_q      <= '0;
      ld_hit_q    <= '0;
      ld_miss_q   <= '0;
      st_hit_q    <= '0;
      st_miss_q   <= '0;
      total_q     <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALLOC_ON_WRITE:  alloc_q <= cfg_data_i[0];
          CFG_WRITE_BACK_MODE: wbm_q   <= cfg_data_i[0];
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          hit_q       <= hit;
          wrote_q     <= wrote;
          cost_q      <= cost;
          rsp_valid_q <= 1'b1;
          total_q     <= total_q + TOTAL_BITS'(cost);
          priority if (hit && store) begin
            st_hit_q <= st_hit_q + CNT_BITS'(1);
          end else if (hit) begin
            ld_hit_q <= ld_hit_q + CNT_BITS'(1);
          end else if (store) begin
            st_miss_q <= st_miss_q + CNT_BITS'(1);
          end else begin
            ld_miss_q <= ld_miss_q + CNT_BITS'(1);
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_valid_o            = rsp_valid_q;
  assign rsp_o.hit              = hit_q;
  assign rsp_o.victim_written   = wrote_q;
  assign rsp_o.access_cycles    = cost_q;
  assign rsp_o.load_hit_count   = ld_hit_q;
  assign rsp_o.load_miss_count  = ld_miss_q;
  assign rsp_o.store_hit_count  = st_hit_q;
  assign rsp_o.store_miss_count = st_miss_q;
  assign rsp_o.cycle_total      = total_q;

  a_rsp_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy))
    else $error("response without a lookup cycle");

  a_accept_to_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && rsp_valid_o == 1'b0))
    else $error("accepted request did not enter lookup");

  a_hit_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.hit) |-> (rsp_o.access_cycles == HIT_COST && !rsp_o.victim_written))
    else $error("hit charged wrong cost or wrote back");

  a_wb_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.victim_written) |->
      (!rsp_o.hit && rsp_o.access_cycles == MEM_COST + MEM_COST))
    else $error("write-back charged wrong cost");

endmodule

// ===== sv/sac_lru_dir_mem.sv =====
// ----------------------------------------------------------------------------
// sac_lru_dir_mem
// One row per set holding tags, valid, dirty and age of all ways, with a
// registered read and a per-row written flag that makes unwritten rows
// read as empty.
// ----------------------------------------------------------------------------
module sac_lru_dir_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [sac_lru_pkg::SET_BITS-1:0] rd_set_i,
  output sac_lru_pkg::row_t             rd_row_o,
  input  logic                          wr_en_i,
  input  logic [sac_lru_pkg::SET_BITS-1:0] wr_set_i,
  input  sac_lru_pkg::row_t             wr_row_i
);
  import sac_lru_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] written_q;
  row_t            rd_q;
  logic            rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_set_i];
      end
    end
  end

  always_comb begin
    rd_row_o = rd_q;
    if (!rd_written_q) begin
      rd_row_o.valid = '0;
      rd_row_o.dirty = '0;
      rd_row_o.age   = '0;
    end
  end

endmodule
